### sv/heading_pid_differential_thrust_core_macros.svh
// Assertion macros for the heading PID core checker.
// Clock and reset are taken as clk and rst in the enclosing scope.
`ifndef HEADING_PID_DIFFERENTIAL_THRUST_CORE_MACROS_SVH
`define HEADING_PID_DIFFERENTIAL_THRUST_CORE_MACROS_SVH

// Same-cycle implication, off during reset
`define HPDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define HPDT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also covers the reset cycles
`define HPDT_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/hpdt_pkg.sv
// Shared constants for the heading PID differential thrust core.
// No dependencies; used by the core and its checker.
package hpdt_pkg;

  // Field and arithmetic widths
  localparam int ANGLE_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int SUM_BITS       = 32;
  localparam int GAIN_BITS      = 32;
  localparam int LIMIT_BITS     = 9;
  localparam int PULSE_BITS     = 11;
  localparam int PROD_CAP_BITS  = 60;

  // Configuration port
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN_I_DT      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN_D_OVER_DT = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ADJUST_LIMIT   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_PULSE   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_DEADBAND_LOW   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_DEADBAND_HIGH  = 3'd6;

  // Register reset values
  localparam logic [GAIN_BITS-1:0]  RST_GAIN_P       = 32'd6;
  localparam logic [LIMIT_BITS-1:0] RST_ADJUST_LIMIT = 9'd1;
  localparam logic [PULSE_BITS-1:0] RST_CENTER       = 11'd1500;
  localparam logic [PULSE_BITS-1:0] RST_DB_LOW       = 11'd1464;
  localparam logic [PULSE_BITS-1:0] RST_DB_HIGH      = 11'd1536;

  // Pulse constants
  localparam logic [PULSE_BITS-1:0] PULSE_MIN     = 11'd1100;
  localparam logic [PULSE_BITS-1:0] PULSE_MAX     = 11'd1900;
  localparam logic [PULSE_BITS-1:0] PULSE_NEUTRAL = 11'd1500;
  localparam logic [PULSE_BITS-1:0] SWITCH_AUTO   = 11'd1200;

endpackage

### sv/heading_pid_differential_thrust_core.sv
// Heading PID controller with differential thrust mixing: 7-stage pipeline.
// Throughput: one item per cycle; the stage chain (input, error/state, multiply,
// saturate, sum, limit/mix, output) takes a new item whenever its first stage
// moves on.
// Reset: synchronous; clears stage valids, error sum, last error, and loads
// the register reset values.
module heading_pid_differential_thrust_core
  import hpdt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] desired_heading,
  input  logic signed [ANGLE_BITS-1:0] measured_heading,
  input  logic                         auto_mode,
  // result item channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PULSE_BITS-1:0]        left_pulse,
  output logic [PULSE_BITS-1:0]        right_pulse,
  output logic [PULSE_BITS-1:0]        rudder_pulse,
  output logic [PULSE_BITS-1:0]        switch_pulse,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready
);

  localparam int NSTG   = 7;
  localparam int PP_W   = GAIN_BITS + ANGLE_BITS;
  localparam int PD_W   = GAIN_BITS + ANGLE_BITS + 1;
  localparam int PI_W   = GAIN_BITS + SUM_BITS;
  localparam int ACC_W  = PROD_CAP_BITS + 2;
  localparam int CMP_A  = (PI_W > PD_W) ? PI_W : PD_W;
  localparam int CMP_W  = (CMP_A > ACC_W) ? CMP_A : ACC_W;
  localparam int ADJ_W  = LIMIT_BITS + GAIN_FRAC_BITS + 1;
  localparam int Q_W    = PULSE_BITS + GAIN_FRAC_BITS + 2;

  localparam logic signed [CMP_W-1:0] PROD_CAP =
    $signed({{(CMP_W-PROD_CAP_BITS-1){1'b0}}, 1'b1, {PROD_CAP_BITS{1'b0}}});
  localparam logic signed [SUM_BITS:0] SUM_MAX =
    $signed({2'b00, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [SUM_BITS:0] SUM_MIN =
    $signed({2'b11, {(SUM_BITS-1){1'b0}}});

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [GAIN_BITS-1:0] gain_p;
  logic signed [GAIN_BITS-1:0] gain_i_dt;
  logic signed [GAIN_BITS-1:0] gain_d_over_dt;
  logic [LIMIT_BITS-1:0]       adjust_limit;
  logic [PULSE_BITS-1:0]       center_pulse;
  logic [PULSE_BITS-1:0]       deadband_low;
  logic [PULSE_BITS-1:0]       deadband_high;
  logic [REG_IDX_BITS-1:0]     reg_idx;

  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= RST_GAIN_P;
      gain_i_dt      <= '0;
      gain_d_over_dt <= '0;
      adjust_limit   <= RST_ADJUST_LIMIT;
      center_pulse   <= RST_CENTER;
      deadband_low   <= RST_DB_LOW;
      deadband_high  <= RST_DB_HIGH;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GAIN_P:         gain_p         <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_I_DT:      gain_i_dt      <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_D_OVER_DT: gain_d_over_dt <= pwdata[GAIN_BITS-1:0];
        REG_ADJUST_LIMIT:   adjust_limit   <= pwdata[LIMIT_BITS-1:0];
        REG_CENTER_PULSE:   center_pulse   <= pwdata[PULSE_BITS-1:0];
        REG_DEADBAND_LOW:   deadband_low   <= pwdata[PULSE_BITS-1:0];
        REG_DEADBAND_HIGH:  deadband_high  <= pwdata[PULSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_GAIN_P:         prdata = DATA_BITS'(unsigned'(gain_p));
      REG_GAIN_I_DT:      prdata = DATA_BITS'(unsigned'(gain_i_dt));
      REG_GAIN_D_OVER_DT: prdata = DATA_BITS'(unsigned'(gain_d_over_dt));
      REG_ADJUST_LIMIT:   prdata = DATA_BITS'(adjust_limit);
      REG_CENTER_PULSE:   prdata = DATA_BITS'(center_pulse);
      REG_DEADBAND_LOW:   prdata = DATA_BITS'(deadband_low);
      REG_DEADBAND_HIGH:  prdata = DATA_BITS'(deadband_high);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or moves on
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-2:0] auto_p;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // mode bit follows the item up to the stage that feeds the output register
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      auto_p[0] <= auto_mode;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (adv[k]) begin
        auto_p[k] <= auto_p[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic signed [ANGLE_BITS-1:0] desired0;
  logic signed [ANGLE_BITS-1:0] measured0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      desired0  <= desired_heading;
      measured0 <= measured_heading;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: wrapped error, saturating error sum, error change
  // ---------------------------------------------------------------------
  logic signed [SUM_BITS-1:0]   error_sum;
  logic signed [ANGLE_BITS-1:0] last_error;
  logic signed [ANGLE_BITS-1:0] err_c;
  logic signed [SUM_BITS:0]     sum_wide;
  logic signed [SUM_BITS-1:0]   error_sum_next;
  logic signed [ANGLE_BITS:0]   diff_c;
  logic                         state_upd;

  assign err_c    = desired0 - measured0;
  assign sum_wide = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(err_c);
  assign diff_c   = (ANGLE_BITS+1)'(err_c) - (ANGLE_BITS+1)'(last_error);

  always_comb begin
    if (sum_wide > SUM_MAX) begin
      error_sum_next = SUM_BITS'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      error_sum_next = SUM_BITS'(SUM_MIN);
    end else begin
      error_sum_next = SUM_BITS'(sum_wide);
    end
  end

  // state moves only for an auto item entering stage 1
  assign state_upd = adv[1] && vld[0] && auto_p[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (state_upd) begin
      error_sum  <= error_sum_next;
      last_error <= err_c;
    end
  end

  logic signed [ANGLE_BITS-1:0] err1;
  logic signed [SUM_BITS-1:0]   sum1;
  logic signed [ANGLE_BITS:0]   diff1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      err1  <= err_c;
      sum1  <= error_sum_next;
      diff1 <= diff_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: gain products
  // ---------------------------------------------------------------------
  logic signed [PP_W-1:0] prod_p2;
  logic signed [PI_W-1:0] prod_i2;
  logic signed [PD_W-1:0] prod_d2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod_p2 <= PP_W'(gain_p) * PP_W'(err1);
      prod_i2 <= PI_W'(gain_i_dt) * PI_W'(sum1);
      prod_d2 <= PD_W'(gain_d_over_dt) * PD_W'(diff1);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: clip each product to +/- 2^60
  // ---------------------------------------------------------------------
  function automatic logic signed [ACC_W-1:0] sat_prod(
    input logic signed [CMP_W-1:0] p
  );
    logic signed [CMP_W-1:0] r;
    if (p > PROD_CAP) begin
      r = PROD_CAP;
    end else if (p < -PROD_CAP) begin
      r = -PROD_CAP;
    end else begin
      r = p;
    end
    return ACC_W'(r);
  endfunction

  logic signed [ACC_W-1:0] sat_p3;
  logic signed [ACC_W-1:0] sat_i3;
  logic signed [ACC_W-1:0] sat_d3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sat_p3 <= sat_prod(CMP_W'(prod_p2));
      sat_i3 <= sat_prod(CMP_W'(prod_i2));
      sat_d3 <= sat_prod(CMP_W'(prod_d2));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: PID sum
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      acc4 <= sat_p3 + sat_i3 + sat_d3;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: limit the adjustment, form raw left and right values
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] lim_c;
  logic signed [ADJ_W-1:0] adj_c;
  logic signed [Q_W-1:0]   center_q;
  logic signed [Q_W-1:0]   left5;
  logic signed [Q_W-1:0]   right5;

  assign lim_c    = ACC_W'($signed({1'b0, adjust_limit, {GAIN_FRAC_BITS{1'b0}}}));
  assign center_q = Q_W'($signed({1'b0, center_pulse, {GAIN_FRAC_BITS{1'b0}}}));

  always_comb begin
    if (acc4 > lim_c) begin
      adj_c = ADJ_W'(lim_c);
    end else if (acc4 < -lim_c) begin
      adj_c = ADJ_W'(-lim_c);
    end else begin
      adj_c = ADJ_W'(acc4);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      left5  <= center_q - Q_W'(adj_c);
      right5 <= center_q + Q_W'(adj_c);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: pulse clamp, deadband snap, output register
  // ---------------------------------------------------------------------
  function automatic logic [PULSE_BITS-1:0] mix_pulse(
    input logic signed [Q_W-1:0] q_in,
    input logic [PULSE_BITS-1:0] center,
    input logic [PULSE_BITS-1:0] db_lo,
    input logic [PULSE_BITS-1:0] db_hi
  );
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] lo_q;
    logic signed [Q_W-1:0] hi_q;
    logic signed [Q_W-1:0] dbl_q;
    logic signed [Q_W-1:0] dbh_q;
    lo_q  = Q_W'($signed({1'b0, PULSE_MIN, {GAIN_FRAC_BITS{1'b0}}}));
    hi_q  = Q_W'($signed({1'b0, PULSE_MAX, {GAIN_FRAC_BITS{1'b0}}}));
    dbl_q = Q_W'($signed({1'b0, db_lo, {GAIN_FRAC_BITS{1'b0}}}));
    dbh_q = Q_W'($signed({1'b0, db_hi, {GAIN_FRAC_BITS{1'b0}}}));
    q = q_in;
    if (q < lo_q) begin
      q = lo_q;
    end
    if (q > hi_q) begin
      q = hi_q;
    end
    if (q < dbh_q && q > dbl_q) begin
      return center;
    end
    return q[GAIN_FRAC_BITS +: PULSE_BITS];
  endfunction

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rudder_pulse <= PULSE_NEUTRAL;
      if (auto_p[5]) begin
        left_pulse   <= mix_pulse(left5, center_pulse, deadband_low, deadband_high);
        right_pulse  <= mix_pulse(right5, center_pulse, deadband_low, deadband_high);
        switch_pulse <= SWITCH_AUTO;
      end else begin
        left_pulse   <= PULSE_NEUTRAL;
        right_pulse  <= PULSE_NEUTRAL;
        switch_pulse <= PULSE_NEUTRAL;
      end
    end
  end

endmodule

### sv/hpdt_checker.sv
// Port-level checker for the heading PID differential thrust core.
// Depends on hpdt_pkg and the assertion macro header; bound to the core.
`include "heading_pid_differential_thrust_core_macros.svh"

module hpdt_checker
  import hpdt_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [PULSE_BITS-1:0]        left_pulse,
  input logic [PULSE_BITS-1:0]        right_pulse,
  input logic [PULSE_BITS-1:0]        rudder_pulse,
  input logic [PULSE_BITS-1:0]        switch_pulse
);

  // a stalled result item stays and holds its values
  `HPDT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(left_pulse) && $stable(right_pulse) && $stable(switch_pulse),
    "stalled result changed")

  // manual items give neutral thrust on both sides
  `HPDT_ASSERT_IMP(a_manual_neutral, out_valid && switch_pulse == PULSE_NEUTRAL,
    left_pulse == PULSE_NEUTRAL && right_pulse == PULSE_NEUTRAL,
    "manual item not neutral")

  // switch pulse only shows the two mode codes
  `HPDT_ASSERT_IMP(a_switch_code, out_valid,
    switch_pulse == SWITCH_AUTO || switch_pulse == PULSE_NEUTRAL, "bad switch pulse")

  // rudder stays neutral
  `HPDT_ASSERT_IMP(a_rudder_neutral, out_valid, rudder_pulse == PULSE_NEUTRAL,
    "rudder not neutral")

  // no result item right after reset
  `HPDT_ASSERT_RST(a_reset_empty, $past(rst), !out_valid, "result valid after reset")

endmodule

bind heading_pid_differential_thrust_core hpdt_checker u_hpdt_checker (.*);

### tb/sv/tb_heading_pid_differential_thrust_core.sv
// Self-checking testbench for heading_pid_differential_thrust_core: drives control
// ticks and APB register writes, predicts each thrust command and checks it in order.
// Depends on hpdt_pkg and the core RTL.
module tb_heading_pid_differential_thrust_core;
  import hpdt_pkg::*;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] left_us;
    logic [PULSE_BITS-1:0] right_us;
    logic [PULSE_BITS-1:0] rudder_us;
    logic [PULSE_BITS-1:0] mode_us;
  } thrust_cmd_t;

  // Address 28 decodes to no register
  localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

  localparam angle_t ANGLE_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam angle_t ANGLE_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
  localparam logic [GAIN_BITS-1:0] GAIN_MOST_NEG = {1'b1, {(GAIN_BITS-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0] GAIN_MOST_POS = {1'b0, {(GAIN_BITS-1){1'b1}}};
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY    = 32'h0001_0000;

  localparam longint PRODUCT_CAP = longint'(1) << PROD_CAP_BITS;
  localparam longint SUM_MAX     = (longint'(1) << (SUM_BITS-1)) - 1;
  localparam longint SUM_MIN     = -(longint'(1) << (SUM_BITS-1));

  localparam int FAULT_REPORTS   = 10;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WINDUP_TICKS    = 40;
  localparam int RANDOM_SEGMENTS = 8;
  localparam int SEGMENT_TICKS   = 120;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  angle_t                desired_heading = '0;
  angle_t                measured_heading = '0;
  logic                  auto_mode = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PULSE_BITS-1:0] left_pulse;
  logic [PULSE_BITS-1:0] right_pulse;
  logic [PULSE_BITS-1:0] rudder_pulse;
  logic [PULSE_BITS-1:0] switch_pulse;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // Predictor copy of the registers and the loop state
  logic signed [GAIN_BITS-1:0] gain_p_q = RST_GAIN_P;
  logic signed [GAIN_BITS-1:0] gain_i_q = '0;
  logic signed [GAIN_BITS-1:0] gain_d_q = '0;
  logic [LIMIT_BITS-1:0]       limit_us = RST_ADJUST_LIMIT;
  logic [PULSE_BITS-1:0]       center_us = RST_CENTER;
  logic [PULSE_BITS-1:0]       db_low_us = RST_DB_LOW;
  logic [PULSE_BITS-1:0]       db_high_us = RST_DB_HIGH;
  longint                      heading_err_sum = 0;
  longint                      prev_heading_err = 0;

  thrust_cmd_t pending_thrust[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int fault_count = 0;
  int ticks_sent = 0;
  int auto_ticks = 0;
  int results_checked = 0;
  int reg_writes = 0;

  always #1 clk = ~clk;

  heading_pid_differential_thrust_core dut (.*);

  // Product clipped to the magnitude cap
  function automatic longint capped_product(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p > PRODUCT_CAP) p = PRODUCT_CAP;
    else if (p < -PRODUCT_CAP) p = -PRODUCT_CAP;
    return p;
  endfunction

  // Clamp to the thruster range, then snap inside the deadband
  function automatic logic [PULSE_BITS-1:0] mix_thrust(input longint q);
    longint floor_q, ceil_q;
    floor_q = longint'(PULSE_MIN) << GAIN_FRAC_BITS;
    ceil_q  = longint'(PULSE_MAX) << GAIN_FRAC_BITS;
    if (q < floor_q) q = floor_q;
    if (q > ceil_q) q = ceil_q;
    if (q > (longint'(db_low_us) << GAIN_FRAC_BITS) &&
        q < (longint'(db_high_us) << GAIN_FRAC_BITS))
      return center_us;
    return PULSE_BITS'(q >>> GAIN_FRAC_BITS);
  endfunction

  // One control tick: updates the loop state, returns the thrust command
  function automatic thrust_cmd_t heading_control_step(input angle_t desired,
                                                       input angle_t measured,
                                                       input logic engaged);
    thrust_cmd_t cmd;
    angle_t err;
    longint sum, delta, acc, lim, cq;
    cmd.rudder_us = PULSE_NEUTRAL;
    if (!engaged) begin
      cmd.left_us  = PULSE_NEUTRAL;
      cmd.right_us = PULSE_NEUTRAL;
      cmd.mode_us  = PULSE_NEUTRAL;
      return cmd;
    end
    err = desired - measured;
    sum = heading_err_sum + longint'(err);
    if (sum > SUM_MAX) sum = SUM_MAX;
    else if (sum < SUM_MIN) sum = SUM_MIN;
    heading_err_sum = sum;
    delta = longint'(err) - prev_heading_err;
    prev_heading_err = longint'(err);
    acc = capped_product(longint'(gain_p_q), longint'(err))
        + capped_product(longint'(gain_i_q), sum)
        + capped_product(longint'(gain_d_q), delta);
    lim = longint'(limit_us) << GAIN_FRAC_BITS;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    cq = longint'(center_us) << GAIN_FRAC_BITS;
    cmd.left_us  = mix_thrust(cq - acc);
    cmd.right_us = mix_thrust(cq + acc);
    cmd.mode_us  = SWITCH_AUTO;
    return cmd;
  endfunction

  // APB write: setup phase, access phase, then the bus goes idle
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:         gain_p_q = value;
      REG_GAIN_I_DT:      gain_i_q = value;
      REG_GAIN_D_OVER_DT: gain_d_q = value;
      REG_ADJUST_LIMIT:   limit_us = value[LIMIT_BITS-1:0];
      REG_CENTER_PULSE:   center_us = value[PULSE_BITS-1:0];
      REG_DEADBAND_LOW:   db_low_us = value[PULSE_BITS-1:0];
      REG_DEADBAND_HIGH:  db_high_us = value[PULSE_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Send one item; valid stays high afterwards unless a gap follows
  task automatic send_tick(input angle_t desired, input angle_t measured,
                           input logic engaged);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    desired_heading  <= desired;
    measured_heading <= measured;
    auto_mode        <= engaged;
    do @(posedge clk); while (in_stall);
    pending_thrust.push_back(heading_control_step(desired, measured, engaged));
    ticks_sent++;
    if (engaged) auto_ticks++;
  endtask

  // Stop sending and wait for every expected command
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_thrust.size() != 0);
  endtask

  function automatic logic [GAIN_BITS-1:0] pick_gain(input int unsigned span);
    logic [GAIN_BITS-1:0] mag;
    case ($urandom_range(7))
      0: return GAIN_MOST_NEG;
      1: return GAIN_MOST_POS;
      2: return '0;
      3: return $urandom();
      default: begin
        mag = $urandom_range(span);
        return ($urandom_range(1) != 0) ? -mag : mag;
      end
    endcase
  endfunction

  // Random noise above a narrow register's width, now and then
  function automatic logic [DATA_BITS-1:0] pad_high(input logic [DATA_BITS-1:0] value,
                                                    input int bits);
    logic [DATA_BITS-1:0] noise;
    noise = ($urandom_range(3) == 0) ? $urandom() : '0;
    return (noise << bits) | value;
  endfunction

  function automatic angle_t corner_heading();
    case ($urandom_range(4))
      0: return ANGLE_MIN;
      1: return ANGLE_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  task automatic load_random_tuning();
    logic [LIMIT_BITS-1:0] lim;
    logic [PULSE_BITS-1:0] mid, lo, hi;
    case ($urandom_range(5))
      0: lim = '0;
      1: lim = '1;
      2: lim = 9'd400;
      default: lim = LIMIT_BITS'($urandom_range(1, 400));
    endcase
    case ($urandom_range(5))
      0: mid = PULSE_MIN;
      1: mid = PULSE_MAX;
      2: mid = PULSE_BITS'($urandom_range(2047));
      default: mid = PULSE_BITS'($urandom_range(1300, 1700));
    endcase
    if ($urandom_range(3) == 0) begin
      // anything at all, reversed edges included
      lo = PULSE_BITS'($urandom_range(2047));
      hi = PULSE_BITS'($urandom_range(2047));
    end else begin
      lo = mid - PULSE_BITS'($urandom_range(60));
      hi = mid + PULSE_BITS'($urandom_range(60));
    end
    write_reg(REG_GAIN_P, pick_gain(4000));
    write_reg(REG_GAIN_I_DT, pick_gain(40));
    write_reg(REG_GAIN_D_OVER_DT, pick_gain(4000));
    write_reg(REG_ADJUST_LIMIT, pad_high(lim, LIMIT_BITS));
    write_reg(REG_CENTER_PULSE, pad_high(mid, PULSE_BITS));
    write_reg(REG_DEADBAND_LOW, pad_high(lo, PULSE_BITS));
    write_reg(REG_DEADBAND_HIGH, pad_high(hi, PULSE_BITS));
  endtask

  // Mostly small heading errors, some wide and some at the angle corners
  task automatic send_random_tick();
    angle_t desired, measured;
    desired = angle_t'($urandom());
    case ($urandom_range(9))
      0: measured = angle_t'($urandom());
      1: begin
        desired  = corner_heading();
        measured = corner_heading();
      end
      default: measured = desired + angle_t'($urandom_range(1200)) - 16'sd600;
    endcase
    send_tick(desired, measured, $urandom_range(99) < 85);
  endtask

  // Registers at their reset values
  task automatic test_reset_values();
    send_tick(16'sd0, 16'sd0, 1'b1);
    send_tick(ANGLE_MAX, 16'sd0, 1'b1);
    send_tick(ANGLE_MIN, 16'sd0, 1'b1);
    send_tick(16'sd5, 16'sd7, 1'b0);
    drain_results();
  endtask

  task automatic test_directed_cases();
    // unity proportional gain: adjustment in us equals the error
    write_reg(REG_GAIN_P, GAIN_UNITY);
    write_reg(REG_GAIN_I_DT, '0);
    write_reg(REG_GAIN_D_OVER_DT, '0);
    write_reg(REG_ADJUST_LIMIT, 400);
    write_reg(REG_CENTER_PULSE, PULSE_NEUTRAL);
    write_reg(REG_DEADBAND_LOW, RST_DB_LOW);
    write_reg(REG_DEADBAND_HIGH, RST_DB_HIGH);
    send_tick(16'sd0, 16'sd0, 1'b1);
    send_tick(16'sd30, 16'sd0, 1'b1);      // both sides snap to center
    send_tick(16'sd36, 16'sd0, 1'b1);      // exactly on the edges: no snap
    send_tick(ANGLE_MIN, ANGLE_MAX, 1'b1); // wraps to +1
    send_tick(ANGLE_MAX, ANGLE_MIN, 1'b1); // wraps to -1
    send_tick(16'sd0, ANGLE_MIN, 1'b1);    // half turn reads as most negative
    send_tick(ANGLE_MIN, 16'sd0, 1'b0);
    send_tick(16'sd1000, 16'sd0, 1'b1);    // clipped at the limit
    drain_results();

    // gains at their extremes, reversed deadband, center above the pulse range
    write_reg(REG_GAIN_P, GAIN_MOST_NEG);
    write_reg(REG_GAIN_I_DT, GAIN_MOST_POS);
    write_reg(REG_GAIN_D_OVER_DT, GAIN_MOST_NEG);
    write_reg(REG_ADJUST_LIMIT, '1);
    write_reg(REG_CENTER_PULSE, '1);
    write_reg(REG_DEADBAND_LOW, PULSE_MAX);
    write_reg(REG_DEADBAND_HIGH, PULSE_MIN);
    write_reg(REG_UNMAPPED, '1);
    send_tick(ANGLE_MAX, ANGLE_MIN, 1'b1);
    send_tick(ANGLE_MIN, ANGLE_MIN, 1'b1);
    send_tick(16'sd0, ANGLE_MAX, 1'b1);
    send_tick(16'sd12345, -16'sd5, 1'b0);
    drain_results();

    // zero limit, deadband spanning everything around a zero center
    write_reg(REG_ADJUST_LIMIT, '0);
    write_reg(REG_CENTER_PULSE, '0);
    write_reg(REG_DEADBAND_LOW, '0);
    write_reg(REG_DEADBAND_HIGH, 32'd2047);
    send_tick(16'sd100, 16'sd0, 1'b1);
    send_tick(-16'sd100, 16'sd0, 1'b1);
    send_tick(16'sd0, 16'sd0, 1'b0);
    drain_results();

    // derivative term alone, center at the low end
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I_DT, '0);
    write_reg(REG_GAIN_D_OVER_DT, GAIN_UNITY);
    write_reg(REG_ADJUST_LIMIT, 200);
    write_reg(REG_CENTER_PULSE, PULSE_MIN);
    write_reg(REG_DEADBAND_LOW, RST_DB_LOW);
    write_reg(REG_DEADBAND_HIGH, RST_DB_HIGH);
    send_tick(16'sd50, 16'sd0, 1'b1);
    send_tick(16'sd50, 16'sd0, 1'b1);
    send_tick(-16'sd50, 16'sd0, 1'b1);
    drain_results();
  endtask

  // New random tuning per segment; idle profile changes every two segments
  task automatic test_random_segments();
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      load_random_tuning();
      repeat (SEGMENT_TICKS) send_random_tick();
      drain_results();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Build up a large negative error sum, unwind part of it, then apply extreme gains
  task automatic test_integral_windup();
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I_DT, 32'd400);
    write_reg(REG_GAIN_D_OVER_DT, '0);
    write_reg(REG_ADJUST_LIMIT, 400);
    write_reg(REG_CENTER_PULSE, PULSE_NEUTRAL);
    write_reg(REG_DEADBAND_LOW, RST_DB_LOW);
    write_reg(REG_DEADBAND_HIGH, RST_DB_HIGH);
    repeat (WINDUP_TICKS) send_tick(ANGLE_MIN, 16'sd0, 1'b1);
    repeat (24) send_tick(ANGLE_MAX, 16'sd0, 1'b1);
    send_tick(ANGLE_MAX, 16'sd0, 1'b0);
    drain_results();
    write_reg(REG_GAIN_I_DT, GAIN_MOST_NEG);
    write_reg(REG_GAIN_P, GAIN_MOST_POS);
    repeat (6) send_tick(ANGLE_MAX, 16'sd0, 1'b1);
    send_tick(ANGLE_MIN, 16'sd0, 1'b1);
    drain_results();
  endtask

  // Receiver stalls
  always @(posedge clk) out_stall <= !rst && ($urandom_range(99) < stall_pct);

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    thrust_cmd_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = {left_pulse, right_pulse, rudder_pulse, switch_pulse};
      if (pending_thrust.size() == 0) begin
        fault_count++;
        if (fault_count <= FAULT_REPORTS)
          $display("unexpected item at %0t: left %0d right %0d rudder %0d switch %0d",
                   $time, seen.left_us, seen.right_us, seen.rudder_us, seen.mode_us);
      end else begin
        want = pending_thrust.pop_front();
        results_checked++;
        if (seen.left_us !== want.left_us || seen.right_us !== want.right_us ||
            seen.rudder_us !== want.rudder_us || seen.mode_us !== want.mode_us) begin
          fault_count++;
          if (fault_count <= FAULT_REPORTS)
            $display("mismatch at %0t: expected L%0d R%0d rud%0d sw%0d, got L%0d R%0d rud%0d sw%0d",
                     $time, want.left_us, want.right_us, want.rudder_us, want.mode_us,
                     seen.left_us, seen.right_us, seen.rudder_us, seen.mode_us);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_random_segments();
    test_integral_windup();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d thrust commands from %0d control ticks, %0d of them in auto mode.",
             results_checked, ticks_sent, auto_ticks);
    $display("%0d register writes; idle profiles: none, input gaps, output stalls, both.",
             reg_writes);
    if (fault_count == 0 && pending_thrust.size() == 0) begin
      $display("tb_heading_pid_differential_thrust_core: clean");
    end else begin
      $display("tb_heading_pid_differential_thrust_core: errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb_heading_pid_differential_thrust_core: errors");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/hpdt_pkg.sv
sv/heading_pid_differential_thrust_core.sv
sv/hpdt_checker.sv
tb/sv/tb_heading_pid_differential_thrust_core.sv
